/* sv/mrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrc_pkg
// shared types, codes and helper functions of the modbus response checker
// ----------------------------------------------------------------------------
package mrc_pkg;

    // input command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // final status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_WRONG_SLAVE = 3'd1;
    localparam logic [2:0] ST_WRONG_FUNC  = 3'd2;
    localparam logic [2:0] ST_CRC_ERROR   = 3'd3;
    localparam logic [2:0] ST_EXCEPTION   = 3'd4;
    localparam logic [2:0] ST_TIMEOUT     = 3'd5;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // register map, index taken from paddr[3:2]
    localparam int unsigned PADDR_W = 4;
    localparam logic [1:0] REG_SLAVE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_FUNCTION_CODE = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [7:0]  SLAVE_ADDRESS_RST = 8'd1;
    localparam logic [6:0]  FUNCTION_CODE_RST = 7'd3;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

    // crc-16/modbus
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int unsigned EXC_BIT = 7;

    // frame lengths
    localparam logic [8:0] HEADER_BYTES   = 9'd5;
    localparam logic [8:0] WRITE_LEN      = 9'd8;
    localparam logic [8:0] MASK_WRITE_LEN = 9'd10;
    localparam logic [8:0] COUNT_MAX      = 9'd511;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    // function codes
    localparam logic [6:0] FC_READ_COILS      = 7'd1;
    localparam logic [6:0] FC_READ_DISCRETE   = 7'd2;
    localparam logic [6:0] FC_READ_HOLDING    = 7'd3;
    localparam logic [6:0] FC_READ_INPUT      = 7'd4;
    localparam logic [6:0] FC_WRITE_COIL      = 7'd5;
    localparam logic [6:0] FC_WRITE_REGISTER  = 7'd6;
    localparam logic [6:0] FC_WRITE_COILS     = 7'd15;
    localparam logic [6:0] FC_WRITE_REGISTERS = 7'd16;
    localparam logic [6:0] FC_MASK_WRITE      = 7'd22;
    localparam logic [6:0] FC_READ_WRITE      = 7'd23;

    // result queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic [7:0] exception_code;
        logic [8:0] frame_length;
        logic       last;
    } result_t;

    // one byte of reflected crc, bit at a time
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // expected frame length, zero for an unknown function code
    function automatic logic [8:0] length_for(input logic [6:0] fc, input logic [7:0] count_byte);
        logic [8:0] len;
        case (fc)
            FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT, FC_READ_WRITE:
                len = HEADER_BYTES + {1'b0, count_byte};
            FC_WRITE_COIL, FC_WRITE_REGISTER, FC_WRITE_COILS, FC_WRITE_REGISTERS:
                len = WRITE_LEN;
            FC_MASK_WRITE:
                len = MASK_WRITE_LEN;
            default:
                len = 9'd0;
        endcase
        return len;
    endfunction

endpackage

/* sv/mrc_in_if.sv */
// ----------------------------------------------------------------------------
// mrc_in_if
// command and received byte channel of the modbus response checker
// ----------------------------------------------------------------------------
interface mrc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

/* sv/mrc_out_if.sv */
// ----------------------------------------------------------------------------
// mrc_out_if
// result channel of the modbus response checker
// ----------------------------------------------------------------------------
interface mrc_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic [7:0] exception_code;
    logic [8:0] frame_length;
    logic       last;

    modport source (output valid, output kind, output data_byte, output status,
                    output exception_code, output frame_length, output last,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input status,
                    input exception_code, input frame_length, input last,
                    output ready);
endinterface

/* sv/modbus_response_checker_top.sv */
// ----------------------------------------------------------------------------
// modbus_response_checker_top
// modbus rtu master response checker: echoes received bytes, checks address,
// function, exception and crc, and reports one final status per transaction
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+----------------------------------
//  rx      | sink      | valid/ready       | command, rx_byte
//  rsp     | source    | valid/ready       | kind, data_byte, status,
//          |           |                   | exception_code, frame_length, last
//  apb     | slave     | psel/penable      | paddr, pwdata, prdata, pready=1
//
//  one transaction per cycle is taken into the input register while the
//  result queue has room, and is worked off from there, so a sustained rate
//  of one item per cycle; a byte that ends a frame makes two results, and
//  the rsp port drains one per cycle while rsp.ready is high, so an item waits
//  in the input register while the result queue holds more than two entries
//  reset clears the transaction state and loads the register defaults;
//  no clearing pass is needed
//  rsp stalls back up through the four-entry result queue into rx.ready
//
module modbus_response_checker_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    mrc_in_if.sink                       rx,
    mrc_out_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  slave_address_reg;
    logic [6:0]  function_code_reg;
    logic [15:0] timeout_ticks_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= mrc_pkg::SLAVE_ADDRESS_RST;
            function_code_reg <= mrc_pkg::FUNCTION_CODE_RST;
            timeout_ticks_reg <= mrc_pkg::TIMEOUT_TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mrc_pkg::REG_SLAVE_ADDRESS: slave_address_reg <= pwdata[7:0];
                mrc_pkg::REG_FUNCTION_CODE: function_code_reg <= pwdata[6:0];
                mrc_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_index)
            mrc_pkg::REG_SLAVE_ADDRESS: prdata = {24'd0, slave_address_reg};
            mrc_pkg::REG_FUNCTION_CODE: prdata = {25'd0, function_code_reg};
            mrc_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic                       in_valid_reg;
    logic [1:0]                 in_cmd_reg;
    logic [7:0]                 in_byte_reg;
    logic [mrc_pkg::QCNT_W-1:0] q_count_reg;
    logic                       q_room;
    logic                       proc_fire;
    logic                       in_fire;

    // room for the two results a single item may make
    assign q_room    = q_count_reg <= mrc_pkg::QCNT_W'(mrc_pkg::QDEPTH - 2);
    assign proc_fire = in_valid_reg && q_room;
    assign rx.ready  = !in_valid_reg || proc_fire;
    assign in_fire   = rx.valid && rx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_cmd_reg  <= rx.command;
            in_byte_reg <= rx.rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // transaction state
    // ------------------------------------------------------------------
    logic        active_reg,     active_next;
    logic [8:0]  count_reg,      count_next;
    logic [15:0] crc_reg,        crc_next;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic [7:0]  second_byte_reg, second_byte_next;
    logic [7:0]  third_byte_reg, third_byte_next;
    logic [15:0] tick_reg,       tick_next;

    logic        push_data;
    logic        push_status;
    logic [2:0]  status_code;
    logic [7:0]  exc_code;
    logic [8:0]  status_len;
    logic [8:0]  count_inc;
    logic [15:0] crc_upd;
    logic [15:0] tick_inc;
    logic [8:0]  exp_len;
    logic        frame_done;

    always_comb
    begin
        active_next      = active_reg;
        count_next       = count_reg;
        crc_next         = crc_reg;
        first_byte_next  = first_byte_reg;
        second_byte_next = second_byte_reg;
        third_byte_next  = third_byte_reg;
        tick_next        = tick_reg;
        push_data        = 1'b0;
        push_status      = 1'b0;
        status_code      = mrc_pkg::ST_OK;
        exc_code         = 8'd0;
        status_len       = count_reg;
        frame_done       = 1'b0;

        count_inc = (count_reg != mrc_pkg::COUNT_MAX) ? count_reg + 9'd1 : count_reg;
        crc_upd   = mrc_pkg::crc_byte(crc_reg, in_byte_reg);
        tick_inc  = (tick_reg != mrc_pkg::TICK_MAX) ? tick_reg + 16'd1 : tick_reg;
        exp_len   = mrc_pkg::length_for(function_code_reg, third_byte_reg);

        if (proc_fire)
        begin
            case (in_cmd_reg)
                mrc_pkg::CMD_START:
                begin
                    // a start during a running transaction is ignored
                    if (!active_reg)
                    begin
                        active_next      = 1'b1;
                        count_next       = 9'd0;
                        crc_next         = mrc_pkg::CRC_INIT;
                        first_byte_next  = 8'd0;
                        second_byte_next = 8'd0;
                        third_byte_next  = 8'd0;
                        tick_next        = 16'd0;
                    end
                end
                mrc_pkg::CMD_TICK:
                begin
                    if (active_reg)
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= timeout_ticks_reg)
                        begin
                            active_next = 1'b0;
                            push_status = 1'b1;
                            status_code = mrc_pkg::ST_TIMEOUT;
                        end
                    end
                end
                mrc_pkg::CMD_BYTE:
                begin
                    if (active_reg)
                    begin
                        if (count_reg == 9'd0)
                        begin
                            first_byte_next = in_byte_reg;
                        end
                        else if (count_reg == 9'd1)
                        begin
                            second_byte_next = in_byte_reg;
                        end
                        else if (count_reg == 9'd2)
                        begin
                            third_byte_next = in_byte_reg;
                        end
                        count_next = count_inc;
                        crc_next   = crc_upd;
                        push_data  = 1'b1;
                        status_len = count_inc;

                        // header bytes are already held once the fifth arrives
                        if (count_inc >= mrc_pkg::HEADER_BYTES)
                        begin
                            if (first_byte_reg != slave_address_reg)
                            begin
                                status_code = mrc_pkg::ST_WRONG_SLAVE;
                                frame_done  = 1'b1;
                            end
                            else if (second_byte_reg[6:0] != function_code_reg)
                            begin
                                status_code = mrc_pkg::ST_WRONG_FUNC;
                                frame_done  = 1'b1;
                            end
                            else if (second_byte_reg[mrc_pkg::EXC_BIT])
                            begin
                                status_code = mrc_pkg::ST_EXCEPTION;
                                exc_code    = third_byte_reg;
                                frame_done  = 1'b1;
                            end
                            else if (exp_len != 9'd0 && count_inc >= exp_len)
                            begin
                                // crc over payload and check bytes leaves zero
                                status_code = (crc_upd == 16'd0) ? mrc_pkg::ST_OK
                                                                 : mrc_pkg::ST_CRC_ERROR;
                                frame_done  = 1'b1;
                            end
                        end

                        if (frame_done)
                        begin
                            active_next = 1'b0;
                            push_status = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            count_reg       <= 9'd0;
            crc_reg         <= mrc_pkg::CRC_INIT;
            first_byte_reg  <= 8'd0;
            second_byte_reg <= 8'd0;
            third_byte_reg  <= 8'd0;
            tick_reg        <= 16'd0;
        end
        else
        begin
            active_reg      <= active_next;
            count_reg       <= count_next;
            crc_reg         <= crc_next;
            first_byte_reg  <= first_byte_next;
            second_byte_reg <= second_byte_next;
            third_byte_reg  <= third_byte_next;
            tick_reg        <= tick_next;
        end
    end

    // ------------------------------------------------------------------
    // result queue: the data echo goes in first, the status right after
    // ------------------------------------------------------------------
    mrc_pkg::result_t           q_mem [mrc_pkg::QDEPTH];
    mrc_pkg::result_t           data_res;
    mrc_pkg::result_t           status_res;
    mrc_pkg::result_t           head;
    logic [mrc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [mrc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [mrc_pkg::QPTR_W-1:0] status_slot;
    logic [mrc_pkg::QCNT_W-1:0] push_cnt;
    logic                       pop;

    always_comb
    begin
        data_res.kind           = mrc_pkg::KIND_DATA;
        data_res.data_byte      = in_byte_reg;
        data_res.status         = mrc_pkg::ST_OK;
        data_res.exception_code = 8'd0;
        data_res.frame_length   = count_inc;
        data_res.last           = 1'b0;

        status_res.kind           = mrc_pkg::KIND_STATUS;
        status_res.data_byte      = 8'd0;
        status_res.status         = status_code;
        status_res.exception_code = exc_code;
        status_res.frame_length   = status_len;
        status_res.last           = 1'b1;
    end

    assign status_slot = wr_ptr_reg + mrc_pkg::QPTR_W'(push_data);
    assign push_cnt    = mrc_pkg::QCNT_W'(push_data) + mrc_pkg::QCNT_W'(push_status);
    assign pop         = rsp.valid && rsp.ready;

    always_ff @(posedge clk)
    begin
        if (push_data)
        begin
            q_mem[wr_ptr_reg] <= data_res;
        end
        if (push_status)
        begin
            q_mem[status_slot] <= status_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_reg + mrc_pkg::QPTR_W'(push_cnt);
            rd_ptr_reg  <= rd_ptr_reg + mrc_pkg::QPTR_W'(pop);
            q_count_reg <= q_count_reg + push_cnt - mrc_pkg::QCNT_W'(pop);
        end
    end

    assign head               = q_mem[rd_ptr_reg];
    assign rsp.valid          = q_count_reg != '0;
    assign rsp.kind           = head.kind;
    assign rsp.data_byte      = head.data_byte;
    assign rsp.status         = head.status;
    assign rsp.exception_code = head.exception_code;
    assign rsp.frame_length   = head.frame_length;
    assign rsp.last           = head.last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= mrc_pkg::QCNT_W'(mrc_pkg::QDEPTH))
        else $error("result queue overflow");

    a_end_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> $past(push_status))
        else $error("transaction ended without a status result");

    a_status_when_active: assert property (@(posedge clk) disable iff (!rst_n)
        push_status |-> active_reg)
        else $error("status result outside a transaction");

    a_head_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.last == rsp.kind))
        else $error("last flag does not match result kind");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(in_cmd_reg)
                                          && $stable(in_byte_reg)))
        else $error("waiting input item lost");
`endif

endmodule

/* tb/sv/mrc_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// mrc_scoreboard_pkg
// tracks the frame state of the response checker from the accepted commands
// and matches every response against the oldest one still awaited
// ----------------------------------------------------------------------------
package mrc_scoreboard_pkg;

    import mrc_pkg::*;

    class response_scoreboard;

        // register copies
        logic [7:0]  slave_addr;
        logic [6:0]  func_code;
        logic [15:0] timeout_lim;

        // frame state
        logic        in_frame;
        logic [8:0]  byte_count;
        logic [8:0]  target_len;
        logic [15:0] crc;
        logic [7:0]  addr_byte;
        logic [7:0]  func_byte;
        logic [7:0]  count_byte;
        logic [15:0] ticks;

        result_t     awaited_results[$];
        int unsigned errors;

        function new();
            slave_addr  = SLAVE_ADDRESS_RST;
            func_code   = FUNCTION_CODE_RST;
            timeout_lim = TIMEOUT_TICKS_RST;
            in_frame    = 1'b0;
            byte_count  = '0;
            target_len  = '0;
            crc         = CRC_INIT;
            addr_byte   = '0;
            func_byte   = '0;
            count_byte  = '0;
            ticks       = '0;
            errors      = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_SLAVE_ADDRESS: slave_addr  = val[7:0];
                REG_FUNCTION_CODE: func_code   = val[6:0];
                REG_TIMEOUT_TICKS: timeout_lim = val[15:0];
                default: ;
            endcase
        endfunction

        // reflected crc, one input bit per step
        function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
            logic feedback;
            for (int k = 0; k < 8; k++)
            begin
                feedback = c[0] ^ b[k];
                c = c >> 1;
                if (feedback)
                    c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        // zero means the function code has no known response length
        function logic [8:0] frame_len(logic [6:0] fc, logic [7:0] cnt);
            if (fc == FC_READ_COILS || fc == FC_READ_DISCRETE || fc == FC_READ_HOLDING ||
                fc == FC_READ_INPUT || fc == FC_READ_WRITE)
                return 9'(cnt) + HEADER_BYTES;
            if (fc == FC_WRITE_COIL || fc == FC_WRITE_REGISTER || fc == FC_WRITE_COILS ||
                fc == FC_WRITE_REGISTERS)
                return WRITE_LEN;
            if (fc == FC_MASK_WRITE)
                return MASK_WRITE_LEN;
            return 9'd0;
        endfunction

        function void push_result(logic k, logic [7:0] d, logic [2:0] st, logic [7:0] exc,
                                  logic lst);
            result_t r;
            r.kind           = k;
            r.data_byte      = d;
            r.status         = st;
            r.exception_code = exc;
            r.frame_length   = byte_count;
            r.last           = lst;
            awaited_results.push_back(r);
        endfunction

        function void note_command(logic [1:0] cmd, logic [7:0] b);
            logic [2:0] st;
            logic [7:0] exc;
            logic       ended;
            st    = ST_OK;
            exc   = '0;
            ended = 1'b0;
            case (cmd)
                CMD_START:
                begin
                    // a start during a running frame is ignored
                    if (!in_frame)
                    begin
                        in_frame   = 1'b1;
                        byte_count = '0;
                        target_len = '0;
                        crc        = CRC_INIT;
                        addr_byte  = '0;
                        func_byte  = '0;
                        count_byte = '0;
                        ticks      = '0;
                    end
                end
                CMD_TICK:
                begin
                    if (in_frame)
                    begin
                        if (ticks != TICK_MAX)
                            ticks = ticks + 16'd1;
                        if (ticks >= timeout_lim)
                        begin
                            in_frame = 1'b0;
                            push_result(KIND_STATUS, 8'd0, ST_TIMEOUT, 8'd0, 1'b1);
                        end
                    end
                end
                CMD_BYTE:
                begin
                    if (in_frame)
                    begin
                        case (byte_count)
                            9'd0: addr_byte  = b;
                            9'd1: func_byte  = b;
                            9'd2: count_byte = b;
                            default: ;
                        endcase
                        if (byte_count != COUNT_MAX)
                            byte_count = byte_count + 9'd1;
                        crc = crc_update(crc, b);
                        push_result(KIND_DATA, b, ST_OK, 8'd0, 1'b0);
                        if (byte_count >= HEADER_BYTES)
                        begin
                            ended = 1'b1;
                            if (addr_byte != slave_addr)
                                st = ST_WRONG_SLAVE;
                            else if (func_byte[6:0] != func_code)
                                st = ST_WRONG_FUNC;
                            else if (func_byte[EXC_BIT])
                            begin
                                st  = ST_EXCEPTION;
                                exc = count_byte;
                            end
                            else
                            begin
                                target_len = frame_len(func_code, count_byte);
                                if (target_len == 0 || byte_count < target_len)
                                    ended = 1'b0;
                                else
                                    st = (crc == 16'd0) ? ST_OK : ST_CRC_ERROR;
                            end
                            if (ended)
                            begin
                                in_frame = 1'b0;
                                push_result(KIND_STATUS, 8'd0, st, exc, 1'b1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function string fmt(result_t r);
            return $sformatf("kind=%0d data=%02h status=%0d exc=%02h len=%0d last=%0d",
                             r.kind, r.data_byte, r.status, r.exception_code,
                             r.frame_length, r.last);
        endfunction

        function void report(string what, result_t want, result_t got);
            errors++;
            if (errors <= 10)
                $display("%s: expected %s, got %s", what, fmt(want), fmt(got));
        endfunction

        function void check_response(result_t got);
            result_t want;
            if (awaited_results.size() == 0)
            begin
                want = '0;
                report("response with nothing awaited", want, got);
                return;
            end
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                got.status !== want.status || got.exception_code !== want.exception_code ||
                got.frame_length !== want.frame_length || got.last !== want.last)
                report("response mismatch", want, got);
        endfunction

    endclass

endpackage

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives commands and received bytes into the modbus response checker, writes
// its registers over apb between phases and checks every response against a
// frame tracker kept in step with the accepted commands
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mrc_pkg::*;
    import mrc_scoreboard_pkg::*;

    // command value the block has no use for
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // cycles allowed for an item still in flight that makes no response
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // kinds of frame the random part builds
    typedef enum int
    {
        FR_GOOD,
        FR_BAD_CRC,
        FR_WRONG_SLAVE,
        FR_WRONG_FUNC,
        FR_EXCEPTION,
        FR_STALLED
    } frame_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    mrc_in_if  rx_if ();
    mrc_out_if rsp_if ();

    modbus_response_checker_top DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    response_scoreboard sb = new();

    // both sides idle at random while this is set
    bit          idling_on = 1'b1;
    // asks the response side for one long hold-off
    bit          hold_req  = 1'b0;
    int unsigned hold_left = 0;
    int unsigned items_offered = 0;
    int unsigned cycle_count = 0;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // response side ready: random stalls, a counted hold-off on request,
    // or always ready during the stretch without idling
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end
        else if (!idling_on)
            rsp_if.ready <= 1'b1;
        else
            rsp_if.ready <= ($urandom_range(0, 99) >= 32);
    end

    // every response transaction is checked at the edge that takes it
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.kind           = rsp_if.kind;
            got.data_byte      = rsp_if.data_byte;
            got.status         = rsp_if.status;
            got.exception_code = rsp_if.exception_code;
            got.frame_length   = rsp_if.frame_length;
            got.last           = rsp_if.last;
            sb.check_response(got);
        end
    end

    // offer one item and hold it until the block takes it; valid stays up
    // afterwards so back-to-back items need no extra edge
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
        if (idling_on)
        begin
            while ($urandom_range(0, 99) < 32)
            begin
                rx_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        rx_if.valid   <= 1'b1;
        rx_if.command <= cmd;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        sb.note_command(cmd, b);
        items_offered++;
    endtask

    // sender stops until every awaited response has come, then lets the
    // pipeline settle for items that make no response
    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // setup cycle, then access cycle; the register takes the value at the
    // edge where the access phase sees pready
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, val);
    endtask

    // end a frame left open: ticks where the timeout is short, else bytes,
    // which always end a frame once the function code is a known one
    task automatic close_frame();
        while (sb.in_frame)
        begin
            if (sb.timeout_lim <= 16'd64)
                send_item(CMD_TICK, 8'($urandom));
            else
                send_item(CMD_BYTE, 8'($urandom));
        end
    endtask

    // append the crc low byte first, optionally corrupt one byte after the
    // count byte, optionally stop short, and send start plus bytes; with
    // stir set, stray starts, ticks and unused commands fall between bytes
    task automatic send_frame(input logic [7:0] body[$], input bit corrupt,
                              input bit stop_short, input bit stir);
        logic [15:0] c;
        int          cut;
        int          idx;
        c = CRC_INIT;
        foreach (body[i])
            c = sb.crc_update(c, body[i]);
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        if (corrupt)
        begin
            idx = $urandom_range(3, body.size() - 1);
            body[idx] = body[idx] ^ 8'(1 << $urandom_range(0, 7));
        end
        cut = stop_short ? $urandom_range(0, body.size() - 1) : body.size();
        send_item(CMD_START, 8'($urandom));
        for (int i = 0; i < cut; i++)
        begin
            if (stir && $urandom_range(0, 99) < 4)
            begin
                case ($urandom_range(0, 2))
                    0:       send_item(CMD_START, 8'($urandom));
                    1:       send_item(CMD_TICK, 8'($urandom));
                    default: send_item(CMD_UNUSED, 8'($urandom));
                endcase
            end
            send_item(CMD_BYTE, body[i]);
        end
    endtask

    // one well-formed response with random content, or one broken in a
    // chosen way, built for the registers as they stand
    task automatic run_frame(input frame_kind_t kind);
        logic [7:0] body[$];
        logic [7:0] t;
        int         len;
        if (sb.in_frame)
            close_frame();
        if (kind == FR_WRONG_SLAVE)
            body.push_back(sb.slave_addr ^ 8'($urandom_range(1, 255)));
        else
            body.push_back(sb.slave_addr);
        if (kind == FR_WRONG_FUNC)
            body.push_back({1'($urandom), sb.func_code ^ 7'($urandom_range(1, 127))});
        else if (kind == FR_EXCEPTION)
            body.push_back({1'b1, sb.func_code});
        else
            body.push_back({1'b0, sb.func_code});
        // mostly short reads, now and then near the longest frame
        if ($urandom_range(0, 99) < 2)
            t = 8'($urandom_range(250, 255));
        else
            t = 8'($urandom_range(0, 8));
        if (kind == FR_EXCEPTION)
            t = 8'($urandom);
        len = sb.frame_len(sb.func_code, t);
        if (kind == FR_EXCEPTION)
            len = HEADER_BYTES;
        else if (len == 0)
            len = HEADER_BYTES + $urandom_range(0, 4);
        body.push_back(t);
        while (body.size() < len - 2)
            body.push_back(8'($urandom));
        send_frame(body, kind == FR_BAD_CRC, kind == FR_STALLED, 1'b1);
        if (kind == FR_STALLED)
            close_frame();
    endtask

    task automatic random_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            send_item(2'($urandom_range(0, 3)), 8'($urandom));
        else if (r < 50)
            run_frame(FR_GOOD);
        else if (r < 60)
            run_frame(FR_BAD_CRC);
        else if (r < 68)
            run_frame(FR_WRONG_SLAVE);
        else if (r < 76)
            run_frame(FR_WRONG_FUNC);
        else if (r < 88)
            run_frame(FR_EXCEPTION);
        else
            run_frame(FR_STALLED);
    endtask

    // one register setting and a batch of random frames under it; with
    // squeeze set the response side first holds off while items keep coming
    task automatic run_phase(input logic [7:0] sa, input logic [6:0] fc,
                             input logic [15:0] tmo, input bit idle_sides,
                             input int unsigned n_items, input bit squeeze);
        int unsigned stop_at;
        wait_drained();
        apb_write(REG_SLAVE_ADDRESS, 32'(sa));
        apb_write(REG_FUNCTION_CODE, 32'(fc));
        apb_write(REG_TIMEOUT_TICKS, 32'(tmo));
        idling_on = idle_sides;
        stop_at   = items_offered + n_items;
        if (squeeze)
        begin
            hold_req = 1'b1;
            while (items_offered < stop_at - n_items + 40)
                random_step();
            wait_drained();
        end
        while (items_offered < stop_at)
            random_step();
    endtask

    function automatic logic [6:0] pick_known_fc();
        case ($urandom_range(0, 9))
            0:       return FC_READ_COILS;
            1:       return FC_READ_DISCRETE;
            2:       return FC_READ_HOLDING;
            3:       return FC_READ_INPUT;
            4:       return FC_WRITE_COIL;
            5:       return FC_WRITE_REGISTER;
            6:       return FC_WRITE_COILS;
            7:       return FC_WRITE_REGISTERS;
            8:       return FC_MASK_WRITE;
            default: return FC_READ_WRITE;
        endcase
    endfunction

    initial
    begin
        logic [7:0] body[$];

        // every block input known from time zero
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.command  = CMD_START;
        rx_if.rx_byte  = 8'd0;
        rsp_if.ready   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset register values: slave 1, read holding
        // registers, long timeout
        // unused command, byte and tick while no transaction is open
        send_item(CMD_UNUSED, 8'hFF);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_TICK, 8'h55);
        // good read response; the frame's own start lands on an open
        // transaction and is ignored
        send_item(CMD_START, 8'h00);
        body = {8'h01, {1'b0, FC_READ_HOLDING}, 8'h02, 8'h00, 8'hFF};
        send_frame(body, 1'b0, 1'b0, 1'b0);
        // exception response ends after five bytes, crc not looked at
        body = {8'h01, {1'b1, FC_READ_HOLDING}, 8'hFF};
        send_frame(body, 1'b0, 1'b0, 1'b0);
        // response for another function
        body = {8'h01, {1'b0, FC_READ_INPUT}, 8'h00};
        send_frame(body, 1'b0, 1'b0, 1'b0);

        // random phases, extremes of every register among them
        run_phase(SLAVE_ADDRESS_RST, FUNCTION_CODE_RST, TIMEOUT_TICKS_RST, 1'b1, 12, 1'b0);
        run_phase(8'd0, FC_WRITE_REGISTERS, 16'd40, 1'b0, 12, 1'b0);
        run_phase(8'd255, FC_MASK_WRITE, 16'd1, 1'b1, 12, 1'b1);
        // function code with no known length: a frame with a matching header ends only by timeout
        run_phase(8'h5A, 7'd127, 16'd12, 1'b1, 12, 1'b0);
        // one frame well past the byte counter's saturation; matching header
        // so the frame stays open under the unknown function code
        if (sb.in_frame)
            close_frame();
        send_item(CMD_START, 8'($urandom));
        send_item(CMD_BYTE, sb.slave_addr);
        send_item(CMD_BYTE, {1'b0, sb.func_code});
        repeat (513) send_item(CMD_BYTE, 8'($urandom));
        close_frame();
        run_phase(8'd17, FC_READ_WRITE, 16'd65535, 1'b1, 12, 1'b0);
        // zero timeout: the first tick of an open transaction ends it
        run_phase(8'd200, FC_READ_COILS, 16'd0, 1'b1, 12, 1'b0);
        run_phase(8'($urandom), pick_known_fc(), 16'($urandom_range(2, 64)), 1'b1, 12, 1'b0);
        run_phase(8'($urandom), pick_known_fc(), 16'd5, 1'b1, 12, 1'b0);

        // all stimulus taken, let the last responses drain
        wait_drained();
        if (sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* files.f */
sv/mrc_pkg.sv
sv/mrc_in_if.sv
sv/mrc_out_if.sv
sv/modbus_response_checker_top.sv
tb/sv/mrc_scoreboard_pkg.sv
tb/sv/testbench.sv
